### rtl/pshp_pkg.sv
// Shared types, layout codes and result formatting for the pack header parser.
package pshp_pkg;

  // Layout codes carried in the result
  localparam logic [1:0] LAY_MPEG1 = 2'd0;
  localparam logic [1:0] LAY_MPEG2 = 2'd1;
  localparam logic [1:0] LAY_OTHER = 2'd2;

  // Byte positions within the header
  localparam logic [4:0] IDX_LAYOUT = 5'd4;
  localparam logic [4:0] IDX_TAIL_HI = 5'd12;
  localparam logic [4:0] IDX_TAIL_LO = 5'd13;

  // Header lengths
  localparam logic [4:0] LEN_OTHER = 5'd4;
  localparam logic [4:0] LEN_MPEG1 = 5'd12;
  localparam logic [4:0] LEN_MPEG2 = 5'd14;

  // Layout selection patterns on the top nibble of the fifth byte
  localparam logic [3:0] NIB_MASK1 = 4'hf;
  localparam logic [3:0] NIB_MPEG1 = 4'h2;
  localparam logic [3:0] NIB_MASK2 = 4'hc;
  localparam logic [3:0] NIB_MPEG2 = 4'h4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] start_code;
    logic [1:0]  layout;
    logic [32:0] clock_base;
    logic [8:0]  clock_ext;
    logic [21:0] mux_rate;
    logic [5:0]  marker_bits;
    logic [3:0]  reserved_lead;
    logic [4:0]  reserved_tail;
    logic [2:0]  stuffing_count;
    logic [4:0]  header_bytes;
  } out_beat_t;

  // Pull the header fields out of the collected bytes
  function automatic out_beat_t format_result(input logic [31:0] code,
                                              input logic [1:0]  lay,
                                              input logic [63:0] f,
                                              input logic [15:0] t);
    out_beat_t r;
    r = '0;
    r.start_code = code;
    r.layout     = lay;
    case (lay)
      LAY_MPEG1: begin
        r.clock_base    = {f[59:57], f[55:41], f[39:25]};
        r.mux_rate      = f[22:1];
        r.marker_bits   = {1'b0, f[0], f[23], f[24], f[40], f[56]};
        r.reserved_lead = f[63:60];
        r.header_bytes  = LEN_MPEG1;
      end
      LAY_MPEG2: begin
        r.clock_base     = {f[61:59], f[57:43], f[41:27]};
        r.clock_ext      = f[25:17];
        r.mux_rate       = {f[15:0], t[15:10]};
        r.marker_bits    = {t[8], t[9], f[16], f[26], f[42], f[58]};
        r.reserved_lead  = {2'b00, f[63:62]};
        r.reserved_tail  = t[7:3];
        r.stuffing_count = t[2:0];
        r.header_bytes   = LEN_MPEG2 + {2'b00, t[2:0]};
      end
      default: begin
        r.header_bytes = LEN_OTHER;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/pshp_in_stage.sv
// Input register stage: holds one accepted byte beat for the parser.
module pshp_in_stage
  import pshp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     stg_valid,
  input  logic     stg_take,
  output in_beat_t stg_data
);

  logic     valid_r;
  in_beat_t data_r;

  // Room when empty or when the held beat leaves this cycle
  assign in_ready  = !valid_r || stg_take;
  assign stg_valid = valid_r;
  assign stg_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule

### rtl/pshp_parser.sv
// Byte-counting parser state and per-byte next-state logic.
module pshp_parser
  import pshp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_beat_t  beat,
  output logic      res_valid,
  output out_beat_t res_data
);

  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [1:0]  layout_r, layout_nxt;
  logic [63:0] field_r, field_nxt;
  logic [31:0] code_r, code_nxt;
  logic [2:0]  stuff_r, stuff_nxt;
  logic        active_r, active_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic        emit;

  // Next state for one byte
  always_comb begin
    logic [3:0] nib;
    logic       other;
    nib            = beat.data_byte[7:4];
    other          = 1'b0;
    emit           = 1'b0;
    byte_index_nxt = byte_index_r;
    layout_nxt     = layout_r;
    field_nxt      = field_r;
    code_nxt       = code_r;
    stuff_nxt      = stuff_r;
    active_nxt     = active_r;
    tail_nxt       = tail_r;

    // First flag restarts the header, dropping any partial one
    if (beat.first) begin
      byte_index_nxt = '0;
      layout_nxt     = LAY_MPEG1;
      field_nxt      = '0;
      code_nxt       = '0;
      stuff_nxt      = '0;
      tail_nxt       = '0;
      active_nxt     = 1'b1;
    end

    if (active_nxt) begin
      if (byte_index_nxt < IDX_LAYOUT) begin
        // start code bytes
        code_nxt       = {code_nxt[23:0], beat.data_byte};
        byte_index_nxt = byte_index_nxt + 5'd1;
      end else begin
        if (byte_index_nxt == IDX_LAYOUT) begin
          if ((nib & NIB_MASK1) == NIB_MPEG1) begin
            layout_nxt = LAY_MPEG1;
          end else if ((nib & NIB_MASK2) == NIB_MPEG2) begin
            layout_nxt = LAY_MPEG2;
          end else begin
            layout_nxt = LAY_OTHER;
            other      = 1'b1;
            emit       = 1'b1;
            active_nxt = 1'b0;
          end
        end
        if (!other) begin
          if (byte_index_nxt < LEN_MPEG1) begin
            // fixed field bytes
            field_nxt      = {field_nxt[55:0], beat.data_byte};
            byte_index_nxt = byte_index_nxt + 5'd1;
            if (byte_index_nxt == LEN_MPEG1 && layout_nxt == LAY_MPEG1) begin
              emit       = 1'b1;
              active_nxt = 1'b0;
            end
          end else if (layout_nxt != LAY_MPEG2) begin
            active_nxt = 1'b0;
          end else if (byte_index_nxt == IDX_TAIL_HI) begin
            tail_nxt       = {beat.data_byte, 8'h00};
            byte_index_nxt = byte_index_nxt + 5'd1;
          end else if (byte_index_nxt == IDX_TAIL_LO) begin
            tail_nxt       = {tail_nxt[15:8], beat.data_byte};
            stuff_nxt      = beat.data_byte[2:0];
            byte_index_nxt = byte_index_nxt + 5'd1;
            if (stuff_nxt == 3'd0) begin
              emit       = 1'b1;
              active_nxt = 1'b0;
            end
          end else if (stuff_nxt != 3'd0) begin
            // skip one stuffing byte
            stuff_nxt      = stuff_nxt - 3'd1;
            byte_index_nxt = byte_index_nxt + 5'd1;
            if (stuff_nxt == 3'd0) begin
              emit       = 1'b1;
              active_nxt = 1'b0;
            end
          end else begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign res_valid = fire && emit;
  assign res_data  = format_result(code_nxt, layout_nxt, field_nxt, tail_nxt);

  // State registers, all cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      layout_r     <= LAY_MPEG1;
      field_r      <= '0;
      code_r       <= '0;
      stuff_r      <= '0;
      active_r     <= 1'b0;
      tail_r       <= '0;
    end else if (fire) begin
      byte_index_r <= byte_index_nxt;
      layout_r     <= layout_nxt;
      field_r      <= field_nxt;
      code_r       <= code_nxt;
      stuff_r      <= stuff_nxt;
      active_r     <= active_nxt;
      tail_r       <= tail_nxt;
    end
  end

endmodule

### rtl/pshp_out_stage.sv
// Result register: holds one finished header result until it is taken.
module pshp_out_stage
  import pshp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  output logic      res_ready,
  input  out_beat_t res_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      valid_r;
  out_beat_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res_data;
    end
  end

endmodule

### rtl/ps_pack_header_parser_top.sv
// Top level of the program stream pack header parser.
//
// Usage: header bytes enter on the in_ channel (valid/ready), one byte per
// beat, with in_data.first set on byte zero of each pack header. A beat with
// first set drops any partial header and starts a new one; bytes that arrive
// with no header in progress are consumed and ignored.
// One result beat leaves on the out_ channel after the last byte of a header:
// byte 5 for an unrecognized layout, byte 12 for MPEG-1, and byte 14 plus the
// stuffing count for MPEG-2.
// Throughput: one byte per cycle while the result register has room;
// the per-byte parse is a single registered pass between the input
// register and the result register. A result is valid once its final
// byte has passed through the input register and the parser has loaded
// the result register.
// Reset (synchronous, rst_n low) empties both registers and clears the
// parser state, so no header is in progress.
// When the receiver stalls, the result register holds its beat; the parser
// then stops, the input register fills and in_ready drops until the result
// is taken.
module ps_pack_header_parser_top
  import pshp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      stg_valid;
  in_beat_t  stg_data;
  logic      fire;
  logic      res_valid;
  logic      res_ready;
  out_beat_t res_data;

  // Parse a byte whenever one is held and the result side has room
  assign fire = stg_valid && res_ready;

  pshp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .stg_valid (stg_valid),
    .stg_take  (fire),
    .stg_data  (stg_data)
  );

  pshp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .beat      (stg_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  pshp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the program stream pack header parser.
`timescale 1ns / 100ps

module testbench;
  import pshp_pkg::*;

  localparam int          CLK_HALF     = 10;
  localparam int          RESET_CYCLES = 9;
  localparam int          ITEM_TARGET  = 1950;
  localparam int          CYCLE_LIMIT  = 250000;
  localparam int          IDLE_PCT     = 29;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          SHOW_MAX     = 10;
  localparam logic [31:0] PACK_CODE    = 32'h0000_01BA;

  // Unrecognized layout behind an all-ones start code
  localparam out_beat_t ONES_OTHER = '{start_code: 32'hFFFF_FFFF, layout: LAY_OTHER,
                                       header_bytes: LEN_OTHER, default: '0};

  typedef struct {
    logic [7:0] data_byte;
    logic       first;
    logic       typed;
    out_beat_t  want;
  } dir_row_t;

  // Directed rows: stray byte, aborted header, unrecognized layout, MPEG-1 all ones
  dir_row_t dir_rows [20] = '{
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'h0F, 1'b0, 1'b1, ONES_OTHER},
    '{8'h00, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'hBA, 1'b0, 1'b0, '0}, '{8'h2F, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // Parser shadow state
  logic [4:0]  hdr_idx    = '0;
  logic [1:0]  hdr_lay    = LAY_MPEG1;
  logic [63:0] hdr_fields = '0;
  logic [31:0] hdr_code   = '0;
  logic [2:0]  stuff_rem  = '0;
  logic        hdr_open   = 1'b0;
  logic [15:0] hdr_tail   = '0;

  out_beat_t expected_headers [$];
  out_beat_t head_want;
  int        mismatches  = 0;
  int        items_taken = 0;
  int        cycle_count = 0;
  bit        quiet       = 1'b0;
  bit        hold_req    = 1'b0;

  ps_pack_header_parser_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Decode the collected header bytes into a result beat
  function automatic out_beat_t pack_fields();
    out_beat_t r;
    logic [63:0] f;
    logic [15:0] t;
    r = '0;
    f = hdr_fields;
    t = hdr_tail;
    r.start_code = hdr_code;
    r.layout     = hdr_lay;
    if (hdr_lay == LAY_MPEG1) begin
      r.clock_base[32:30] = f[59:57];
      r.clock_base[29:15] = f[55:41];
      r.clock_base[14:0]  = f[39:25];
      r.mux_rate          = f[22:1];
      r.marker_bits[0]    = f[56];
      r.marker_bits[1]    = f[40];
      r.marker_bits[2]    = f[24];
      r.marker_bits[3]    = f[23];
      r.marker_bits[4]    = f[0];
      r.reserved_lead     = f[63:60];
      r.header_bytes      = LEN_MPEG1;
    end else if (hdr_lay == LAY_MPEG2) begin
      r.clock_base[32:30] = f[61:59];
      r.clock_base[29:15] = f[57:43];
      r.clock_base[14:0]  = f[41:27];
      r.clock_ext         = f[25:17];
      r.mux_rate[21:6]    = f[15:0];
      r.mux_rate[5:0]     = t[15:10];
      r.marker_bits[0]    = f[58];
      r.marker_bits[1]    = f[42];
      r.marker_bits[2]    = f[26];
      r.marker_bits[3]    = f[16];
      r.marker_bits[4]    = t[9];
      r.marker_bits[5]    = t[8];
      r.reserved_lead     = 4'(f[63:62]);
      r.reserved_tail     = t[7:3];
      r.stuffing_count    = t[2:0];
      r.header_bytes      = LEN_MPEG2 + 5'(t[2:0]);
    end else begin
      r.header_bytes = LEN_OTHER;
    end
    return r;
  endfunction

  // One byte through the shadow parser; taken is low when the byte is ignored
  task automatic parse_header_byte(input in_beat_t b, output bit emitted, output bit taken,
                                   output out_beat_t res);
    logic [3:0] nib;
    nib     = b.data_byte[7:4];
    emitted = 1'b0;
    taken   = 1'b0;
    res     = '0;
    if (b.first) begin
      hdr_idx    = '0;
      hdr_lay    = LAY_MPEG1;
      hdr_fields = '0;
      hdr_code   = '0;
      stuff_rem  = '0;
      hdr_tail   = '0;
      hdr_open   = 1'b1;
    end
    if (!hdr_open) return;
    taken = 1'b1;
    if (hdr_idx < IDX_LAYOUT) begin
      hdr_code = {hdr_code[23:0], b.data_byte};
      hdr_idx++;
      return;
    end
    if (hdr_idx == IDX_LAYOUT) begin
      if ((nib & NIB_MASK1) == NIB_MPEG1) begin
        hdr_lay = LAY_MPEG1;
      end else if ((nib & NIB_MASK2) == NIB_MPEG2) begin
        hdr_lay = LAY_MPEG2;
      end else begin
        // unrecognized: result on this byte, which is not counted
        hdr_lay  = LAY_OTHER;
        res      = pack_fields();
        emitted  = 1'b1;
        hdr_open = 1'b0;
        return;
      end
    end
    if (hdr_idx < IDX_TAIL_HI) begin
      hdr_fields = {hdr_fields[55:0], b.data_byte};
      hdr_idx++;
      if (hdr_idx == LEN_MPEG1 && hdr_lay == LAY_MPEG1) begin
        res      = pack_fields();
        emitted  = 1'b1;
        hdr_open = 1'b0;
      end
      return;
    end
    if (hdr_lay != LAY_MPEG2) begin
      hdr_open = 1'b0;
      return;
    end
    if (hdr_idx == IDX_TAIL_HI) begin
      hdr_tail = {b.data_byte, 8'h00};
      hdr_idx++;
      return;
    end
    if (hdr_idx == IDX_TAIL_LO) begin
      hdr_tail[7:0] = b.data_byte;
      stuff_rem     = b.data_byte[2:0];
      hdr_idx++;
      if (stuff_rem == 0) begin
        res      = pack_fields();
        emitted  = 1'b1;
        hdr_open = 1'b0;
      end
      return;
    end
    // stuffing bytes are skipped
    if (stuff_rem > 0) begin
      stuff_rem--;
      hdr_idx++;
      if (stuff_rem == 0) begin
        res      = pack_fields();
        emitted  = 1'b1;
        hdr_open = 1'b0;
      end
      return;
    end
    hdr_open = 1'b0;
  endtask

  // Offer one beat, wait for acceptance, then predict
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    bit        emitted;
    bit        taken;
    out_beat_t res;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    parse_header_byte(b, emitted, taken, res);
    if (taken) items_taken++;
    if (emitted) expected_headers.push_back(typed ? want : res);
  endtask

  function automatic in_beat_t mk_beat(input logic [7:0] d, input logic f);
    in_beat_t b;
    b.data_byte = d;
    b.first     = f;
    return b;
  endfunction

  // One random header: mostly well formed, some noise and truncated headers
  task automatic send_header();
    in_beat_t    hdr [$];
    int          kind;
    int          pick;
    int          cut;
    logic [31:0] code;
    logic [7:0]  sel;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) hdr.push_back(mk_beat(8'($urandom), $urandom_range(9) == 0));
    end else begin
      code = ($urandom_range(4) == 0) ? 32'($urandom) : PACK_CODE;
      hdr.push_back(mk_beat(code[31:24], 1'b1));
      hdr.push_back(mk_beat(code[23:16], 1'b0));
      hdr.push_back(mk_beat(code[15:8], 1'b0));
      hdr.push_back(mk_beat(code[7:0], 1'b0));
      pick = $urandom_range(99);
      if (pick < 40) begin
        hdr.push_back(mk_beat({NIB_MPEG1, 4'($urandom)}, 1'b0));
        repeat (7) hdr.push_back(mk_beat(8'($urandom), 1'b0));
      end else if (pick < 88) begin
        hdr.push_back(mk_beat({NIB_MPEG2[3:2], 6'($urandom)}, 1'b0));
        repeat (8) hdr.push_back(mk_beat(8'($urandom), 1'b0));
        sel = 8'($urandom);
        hdr.push_back(mk_beat(sel, 1'b0));
        repeat (sel[2:0]) hdr.push_back(mk_beat(8'($urandom), 1'b0));
      end else begin
        do sel = 8'($urandom);
        while (sel[7:4] == NIB_MPEG1 || (sel[7:4] & NIB_MASK2) == NIB_MPEG2);
        hdr.push_back(mk_beat(sel, 1'b0));
      end
      // broken header: cut short, the next first byte aborts it
      if (kind >= 92) begin
        cut = $urandom_range(1, hdr.size() - 1);
        while (hdr.size() > cut) void'(hdr.pop_back());
      end
    end
    foreach (hdr[i]) send_beat(hdr[i], 1'b0, '0);
  endtask

  // Result side ready, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("mismatch %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_headers.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX) $display("unexpected result beat 0x%0h", out_data);
      end else begin
        head_want = expected_headers.pop_front();
        check_field("start_code", 64'(out_data.start_code), 64'(head_want.start_code));
        check_field("layout", 64'(out_data.layout), 64'(head_want.layout));
        check_field("clock_base", 64'(out_data.clock_base), 64'(head_want.clock_base));
        check_field("clock_ext", 64'(out_data.clock_ext), 64'(head_want.clock_ext));
        check_field("mux_rate", 64'(out_data.mux_rate), 64'(head_want.mux_rate));
        check_field("marker_bits", 64'(out_data.marker_bits), 64'(head_want.marker_bits));
        check_field("reserved_lead", 64'(out_data.reserved_lead),
                    64'(head_want.reserved_lead));
        check_field("reserved_tail", 64'(out_data.reserved_tail),
                    64'(head_want.reserved_tail));
        check_field("stuffing_count", 64'(out_data.stuffing_count),
                    64'(head_want.stuffing_count));
        check_field("header_bytes", 64'(out_data.header_bytes),
                    64'(head_want.header_bytes));
      end
    end
  end

  // Stimulus
  initial begin
    int hdr_n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat(mk_beat(dir_rows[i].data_byte, dir_rows[i].first), dir_rows[i].typed,
                dir_rows[i].want);

    items_taken = 0;
    hdr_n = 0;
    while (items_taken < ITEM_TARGET) begin
      quiet = (hdr_n >= 60 && hdr_n < 110);
      if (hdr_n == 40) hold_req = 1'b1;
      // sender pause until the block has drained
      if (hdr_n == 140) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_headers.size() != 0);
      end
      send_header();
      hdr_n++;
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (expected_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_headers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pshp_pkg.sv
rtl/pshp_in_stage.sv
rtl/pshp_parser.sv
rtl/pshp_out_stage.sv
rtl/ps_pack_header_parser_top.sv
dv/testbench.sv
